/* hdl/cat_pkg.sv */
// Package for the countdown action table: item structs, opcode and status
// codes, and the command/status structs between controller and datapath.
// No dependencies.
package cat_pkg;

  localparam logic [2:0] OP_START_REC = 3'd0;
  localparam logic [2:0] OP_START_CD  = 3'd1;
  localparam logic [2:0] OP_LENGTHEN  = 3'd2;
  localparam logic [2:0] OP_CLEAR     = 3'd3;
  localparam logic [2:0] OP_RUN       = 3'd4;
  localparam logic [2:0] OP_TICK      = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_BADID   = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         action_id;
    logic signed [15:0] time_value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired_valid;
    logic [7:0] fired_id;
    logic       last;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic fetch_rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic is_len;
  } sts_t;

endpackage

/* hdl/cat_ctrl.sv */
// Sequencer for the countdown action table: accept, slot scan, drain, fetch, finish.
// Depends on cat_pkg.
module cat_ctrl import cat_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] scan_addr
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_FETCH = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = sts.skip ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = sts.is_len ? S_FETCH : S_DONE;
      end
      S_FETCH: begin
        cmd.fetch_rd = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign scan_addr = idx_r;

endmodule

/* hdl/cat_dpath.sv */
// Datapath for the countdown action table: slot memories, valid bits,
// slot evaluation, saturating count update and result register.
// Depends on cat_pkg.
module cat_dpath import cat_pkg::*; #(
  parameter int SLOTS     = 32,
  parameter int ID_BITS   = 8,
  parameter int TIME_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] scan_addr,
  output sts_t sts,
  output logic out_valid,
  output out_t out_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW    = (ID_BITS > 8) ? ID_BITS : 8;
  localparam int SW    = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
  localparam logic signed [SW-1:0] TMAX = SW'((64'sd1 <<< (TIME_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] TMIN = SW'(-(64'sd1 <<< (TIME_BITS - 1)));

  // item payload
  logic [2:0]                op_r;
  logic [ID_BITS-1:0]        id_r;
  logic signed [15:0]        tv_r;
  logic [AW-1:0]             in_id_x;
  logic [ID_BITS-1:0]        in_id;

  // slot storage
  logic [ID_BITS-1:0]          action_mem [SLOTS];
  logic signed [TIME_BITS-1:0] count_mem  [SLOTS];
  logic [SLOTS-1:0]            valid_r;

  // registered read port and evaluation stage
  logic [IDX_W-1:0]            rd_addr;
  logic [ID_BITS-1:0]          act_q;
  logic signed [TIME_BITS-1:0] cnt_q;
  logic                        vld_q;
  logic                        ev_en_r;
  logic [IDX_W-1:0]            ev_idx_r;

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_id_r, pend_id_nxt;
  logic             out_v_r, out_v_nxt;
  out_t             out_d_r, out_d_nxt;

  logic                        cnt_we, act_we, vset, vclr, fire, cnt_pos;
  logic [IDX_W-1:0]            cnt_wa, vidx;
  logic signed [TIME_BITS-1:0] cnt_wd, cnt_sat;
  logic signed [SW-1:0]        base_x, sum_x;
  logic [AW-1:0]               act_x;
  logic [1:0]                  fin_status;

  assign in_id_x = AW'(in_data.action_id);
  assign in_id   = in_id_x[ID_BITS-1:0];
  assign act_x   = AW'(act_q);

  assign sts.skip   = (in_data.opcode > OP_TICK) ||
                      ((in_data.opcode <= OP_CLEAR) && (in_id == '0));
  assign sts.is_len = (op_r == OP_LENGTHEN);

  assign rd_addr = cmd.fetch_rd ? fidx_r : scan_addr;
  assign cnt_pos = !cnt_q[TIME_BITS-1] && (cnt_q != '0);

  // saturating add: start countdown adds to zero, lengthen to the fetched count
  assign base_x  = (op_r == OP_LENGTHEN) ? SW'(cnt_q) : '0;
  assign sum_x   = base_x + SW'(tv_r);
  assign cnt_sat = (sum_x > TMAX) ? TIME_BITS'(TMAX) :
                   (sum_x < TMIN) ? TIME_BITS'(TMIN) : TIME_BITS'(sum_x);

  always_comb begin
    if ((op_r <= OP_CLEAR) && (id_r == '0)) begin
      fin_status = ST_BADID;
    end else if ((op_r <= OP_START_CD) && !found_r) begin
      fin_status = ST_FULL;
    end else if ((op_r <= OP_CLEAR) && !found_r) begin
      fin_status = ST_MISSING;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_comb begin
    found_nxt   = found_r;
    fidx_nxt    = fidx_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    out_v_nxt   = 1'b0;
    out_d_nxt   = out_d_r;
    cnt_we      = 1'b0;
    cnt_wa      = ev_idx_r;
    cnt_wd      = cnt_q - TIME_BITS'(1);
    act_we      = 1'b0;
    vset        = 1'b0;
    vclr        = 1'b0;
    vidx        = ev_idx_r;
    fire        = 1'b0;

    if (cmd.load) begin
      found_nxt  = 1'b0;
      pend_v_nxt = 1'b0;
    end

    if (ev_en_r) begin
      case (op_r)
        OP_START_REC, OP_START_CD: begin
          if (!found_r && !vld_q) begin
            found_nxt = 1'b1;
            fidx_nxt  = ev_idx_r;
          end
        end
        OP_LENGTHEN, OP_CLEAR: begin
          if (!found_r && vld_q && (act_q == id_r)) begin
            found_nxt = 1'b1;
            fidx_nxt  = ev_idx_r;
          end
        end
        OP_RUN: begin
          fire = vld_q && (cnt_q == '1);
        end
        OP_TICK: begin
          if (vld_q && cnt_pos) begin
            cnt_we = 1'b1;
            if (cnt_q == TIME_BITS'(1)) begin
              fire = 1'b1;
              vclr = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // hold one firing back until the next one or the end shows which is last
    if (fire) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = '{status: ST_OK, fired_valid: 1'b1, fired_id: pend_id_r, last: 1'b0};
      end
      pend_v_nxt  = 1'b1;
      pend_id_nxt = act_x[7:0];
    end

    if (cmd.finish) begin
      out_v_nxt = 1'b1;
      if (pend_v_r) begin
        out_d_nxt = '{status: ST_OK, fired_valid: 1'b1, fired_id: pend_id_r, last: 1'b1};
      end else begin
        out_d_nxt = '{status: fin_status, fired_valid: 1'b0, fired_id: 8'd0, last: 1'b1};
      end
      vidx   = fidx_r;
      cnt_wa = fidx_r;
      case (op_r)
        OP_START_REC: begin
          act_we = found_r;
          vset   = found_r;
          cnt_we = found_r;
          cnt_wd = '1;
        end
        OP_START_CD: begin
          act_we = found_r;
          vset   = found_r;
          cnt_we = found_r;
          cnt_wd = cnt_sat;
        end
        OP_LENGTHEN: begin
          cnt_we = found_r;
          cnt_wd = cnt_sat;
        end
        OP_CLEAR: begin
          vclr = found_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_data.opcode;
      id_r <= in_id;
      tv_r <= in_data.time_value;
    end
    if (cmd.scan_rd || cmd.fetch_rd) begin
      act_q <= action_mem[rd_addr];
      cnt_q <= count_mem[rd_addr];
      vld_q <= valid_r[rd_addr];
    end
    if (act_we) begin
      action_mem[fidx_r] <= id_r;
    end
    if (cnt_we) begin
      count_mem[cnt_wa] <= cnt_wd;
    end
    ev_idx_r  <= rd_addr;
    fidx_r    <= fidx_nxt;
    pend_id_r <= pend_id_nxt;
    out_d_r   <= out_d_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      ev_en_r  <= 1'b0;
      found_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (vset) begin
        valid_r[vidx] <= 1'b1;
      end else if (vclr) begin
        valid_r[vidx] <= 1'b0;
      end
      ev_en_r  <= cmd.scan_rd;
      found_r  <= found_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

/* hdl/countdown_action_table.sv */
// Top level of the countdown action table: controller plus datapath.
// Depends on cat_pkg, cat_ctrl and cat_dpath.
//
//   channel  | ports                   | handshake
//   ---------+-------------------------+-------------------------------------
//   input    | start, busy, in_data    | item taken when start && !busy
//   result   | out_valid, out_data     | one-cycle strobe, always taken
//
// Sequence: an item with a bad id or an unused opcode goes from acceptance
// straight to the finish state; any other item walks all SLOTS slots through
// the memory read port, one a cycle, then passes a drain state and, for
// lengthen, which reads the found count once more, a fetch state before finish.
// Results leave a register; run and tick may give one per slot during the
// walk, and the final one appears in the same cycle that busy drops.
// Reset: synchronous, active low; it clears the slot valid bits at once, so
// every slot is empty with no clearing pass. Counts are not reset.
// Stalls: the receiver cannot stall; only busy throttles the sender.
module countdown_action_table import cat_pkg::*; #(
  parameter int SLOTS     = 32,
  parameter int ID_BITS   = 8,
  parameter int TIME_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] scan_addr;

  // sequencer: owns the scan counter and the phase of each item
  cat_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .sts      (sts),
    .cmd      (cmd),
    .scan_addr(scan_addr)
  );

  // slot memories, per-slot evaluation and the result register
  cat_dpath #(
    .SLOTS    (SLOTS),
    .ID_BITS  (ID_BITS),
    .TIME_BITS(TIME_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .scan_addr(scan_addr),
    .sts      (sts),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // an accepted item always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result that fires nothing is always the only, final one of its item
  a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.fired_valid) |-> out_data.last)
    else $error("non-firing result not marked last");

  // an error status never comes with a fired id
  a_err_nofire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |-> (!out_data.fired_valid && out_data.last))
    else $error("error result carries a fired id");

  // the final result of an item is never followed at once by another result
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |=> !out_valid)
    else $error("result directly after a final result");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for countdown_action_table: directed and random command items,
// each result checked against an in-bench model of the slot table.
// Depends on cat_pkg and the countdown_action_table RTL.
`timescale 1ns / 100ps

module testbench;
  import cat_pkg::*;

  localparam int SLOTS       = 32;
  localparam int HALF_PERIOD = 5;
  // Slot walk plus the final result register, with some slack.
  localparam int SETTLE      = SLOTS + 12;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  countdown_action_table #(
    .SLOTS     (SLOTS),
    .ID_BITS   (8),
    .TIME_BITS (16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Model of the slot table: id 0 marks an empty slot, counts are signed.
  logic [7:0] slot_id [SLOTS];
  int         slot_cnt [SLOTS];

  // Results the table still owes, oldest first.
  out_t pending_results [$];

  int  failures = 0;
  // Set to run a stretch of items back to back with no idle cycles.
  bit  steady   = 1'b0;

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  function int first_slot(logic [7:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (slot_id[i] == key) return i;
    return -1;
  endfunction

  function int sat_time(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function out_t make_result(logic [1:0] st, logic vld, logic [7:0] id, logic lst);
    out_t r;
    r.status      = st;
    r.fired_valid = vld;
    r.fired_id    = id;
    r.last        = lst;
    return r;
  endfunction

  // Apply one accepted command to the table model and queue what it should emit.
  function automatic void predict_results(in_t cmd);
    int         idx;
    int         amount;
    logic [1:0] st;
    out_t       fired [$];
    amount = int'($signed(cmd.time_value));
    st     = ST_OK;
    case (cmd.opcode)
      OP_START_REC, OP_START_CD, OP_LENGTHEN, OP_CLEAR: begin
        if (cmd.action_id == 8'd0) begin
          st = ST_BADID;
        end else if (cmd.opcode == OP_START_REC || cmd.opcode == OP_START_CD) begin
          idx = first_slot(8'd0);
          if (idx < 0) begin
            st = ST_FULL;
          end else begin
            slot_id[idx]  = cmd.action_id;
            // A recurring action is a slot whose count is minus one.
            slot_cnt[idx] = (cmd.opcode == OP_START_REC) ? -1 : sat_time(amount);
          end
        end else begin
          idx = first_slot(cmd.action_id);
          if (idx < 0) begin
            st = ST_MISSING;
          end else if (cmd.opcode == OP_LENGTHEN) begin
            slot_cnt[idx] = sat_time(longint'(slot_cnt[idx]) + amount);
          end else begin
            slot_id[idx] = 8'd0;
          end
        end
        pending_results.push_back(make_result(st, 1'b0, 8'd0, 1'b1));
      end
      OP_RUN, OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_id[i] != 8'd0) begin
            if (cmd.opcode == OP_RUN) begin
              if (slot_cnt[i] == -1) fired.push_back(make_result(ST_OK, 1'b1, slot_id[i], 1'b0));
            end else if (slot_cnt[i] > 0) begin
              slot_cnt[i]--;
              if (slot_cnt[i] == 0) begin
                fired.push_back(make_result(ST_OK, 1'b1, slot_id[i], 1'b0));
                slot_id[i] = 8'd0;
              end
            end
          end
        end
        if (fired.size() == 0) begin
          pending_results.push_back(make_result(ST_OK, 1'b0, 8'd0, 1'b1));
        end else begin
          fired[fired.size() - 1].last = 1'b1;
          foreach (fired[k]) pending_results.push_back(fired[k]);
        end
      end
      default: begin
        // Unused opcodes leave the table alone and give one empty result.
        pending_results.push_back(make_result(ST_OK, 1'b0, 8'd0, 1'b1));
      end
    endcase
  endfunction

  // Idle the input for a random number of cycles: mostly none or a few, now and
  // then a long stretch. Drop start only when a gap is taken, so start gets a
  // single assignment in the step where the previous item was accepted.
  task idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (steady || r < 50) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one item, hold it until the table takes it, then predict its results.
  // Called in the time step of a rising edge.
  task send_item(logic [2:0] op, logic [7:0] id, logic [15:0] tv);
    in_t cmd;
    cmd.opcode     = op;
    cmd.action_id  = id;
    cmd.time_value = tv;
    idle_gap();
    start   <= 1'b1;
    in_data <= cmd;
    // Accept on the first edge that sees busy low; values read here are pre-edge.
    do @(posedge clk); while (busy);
    predict_results(cmd);
  endtask

  // Ids cluster on a few values so lengthen and clear find their slots.
  function logic [7:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(1, 12));
    if (r < 95) return 8'($urandom_range(0, 255));
    return (r < 97) ? 8'd255 : 8'd128;
  endfunction

  // Counts mostly short so ticks fire often; keep the odd extreme and negative.
  function logic [15:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom_range(1, 6));
    if (r < 65) return 16'hFFFF;
    if (r < 70) return 16'h0000;
    if (r < 80) return 16'(-$urandom_range(2, 4));
    if (r < 84) return 16'h7FFF;
    if (r < 88) return 16'h8000;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Send n random items drawn with the given weights; a small share is noise:
  // any opcode, often with id zero.
  task random_items(int n, int w_start, int w_modify, int w_run, int w_tick);
    int          pick;
    int          total;
    logic [2:0]  op;
    logic [7:0]  id;
    total = w_start + w_modify + w_run + w_tick + 5;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, total - 1);
      id   = pick_id();
      if (pick < w_start) begin
        op = 3'($urandom_range(0, 1));
      end else if (pick < w_start + w_modify) begin
        op = 3'($urandom_range(2, 3));
      end else if (pick < w_start + w_modify + w_run) begin
        op = OP_RUN;
      end else if (pick < w_start + w_modify + w_run + w_tick) begin
        op = OP_TICK;
      end else begin
        op = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 1) id = 8'd0;
      end
      send_item(op, id, pick_time());
    end
    steady = 1'b0;
  endtask

  task test_invalid_ids();
    send_item(OP_START_REC, 8'd0, 16'd5);
    send_item(OP_START_CD,  8'd0, 16'd5);
    send_item(OP_LENGTHEN,  8'd0, 16'd5);
    send_item(OP_CLEAR,     8'd0, 16'd5);
  endtask

  task test_empty_table();
    send_item(OP_RUN,      8'd7,  16'h1234);
    send_item(OP_TICK,     8'd9,  16'hFFFF);
    send_item(OP_LENGTHEN, 8'd42, 16'd1);
    send_item(OP_CLEAR,    8'd42, 16'd0);
    send_item(3'd6,        8'hFF, 16'hFFFF);
    send_item(3'd7,        8'hAA, 16'h5555);
  endtask

  task test_count_extremes();
    send_item(OP_START_CD,  8'd255, 16'd1);
    send_item(OP_START_CD,  8'd1,   16'h7FFF);
    send_item(OP_START_CD,  8'd2,   16'h8000);
    send_item(OP_START_CD,  8'd3,   16'd0);
    send_item(OP_START_REC, 8'd4,   16'h4321);
    // A countdown started at minus one behaves as a recurring action.
    send_item(OP_START_CD,  8'd5,   16'hFFFF);
    // Saturate at both ends of the count range.
    send_item(OP_LENGTHEN,  8'd1,   16'h7FFF);
    send_item(OP_LENGTHEN,  8'd2,   16'h8000);
    // Turn the recurring action into a countdown of one.
    send_item(OP_LENGTHEN,  8'd4,   16'd2);
    send_item(OP_RUN,       8'd0,   16'd0);
    send_item(OP_TICK,      8'd0,   16'd0);
    send_item(OP_CLEAR,     8'd3,   16'd0);
    send_item(OP_CLEAR,     8'd5,   16'd0);
  endtask

  task test_fill_to_full();
    random_items(40, 85, 5, 5, 5);
  endtask

  task test_random_traffic();
    random_items(277, 35, 30, 10, 25);
  endtask

  task test_drain_by_ticks();
    random_items(70, 5, 20, 10, 65);
  endtask

  // Check every result strobe against the oldest outstanding prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status=%0d valid=%0d id=%0d last=%0d",
                               out_data.status, out_data.fired_valid, out_data.fired_id,
                               out_data.last));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.fired_valid !== want.fired_valid ||
            out_data.fired_id !== want.fired_id || out_data.last !== want.last)
          note_failure($sformatf(
            "mismatch: expected status=%0d valid=%0d id=%0d last=%0d, got %0d %0d %0d %0d",
            want.status, want.fired_valid, want.fired_id, want.last, out_data.status,
            out_data.fired_valid, out_data.fired_id, out_data.last));
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_id[i]  = 8'd0;
      slot_cnt[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_invalid_ids();
    test_empty_table();
    test_count_extremes();
    test_fill_to_full();
    test_random_traffic();
    test_drain_by_ticks();

    start <= 1'b0;
    // Drain outstanding results, then watch a while for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));

    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
